// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define TFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define TFR_ASSERT_NXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/tfr_pkg.sv -----
// Shared widths, register map and format codes for the texel expander.
`default_nettype none

package tfr_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned TEXEL_W    = 32;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned TOTAL_W    = 21;

  // Register index, taken from paddr[2]
  localparam logic REG_SOURCE_MODE = 1'b0;
  localparam logic REG_TEXEL_TOTAL = 1'b1;

  // Source format codes
  localparam logic [MODE_W-1:0] MODE_RGBA16  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_RGBA32  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_IA16    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_IA8     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_IA4     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_I8      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_I4      = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MAGENTA = 4'd7;
  // First code that yields no texels (YUV, color index, unsupported size)
  localparam logic [MODE_W-1:0] MODE_UNIMPL  = 4'd8;

  localparam logic [TEXEL_W-1:0] MAGENTA_TEXEL = 32'h00FF_00FF;

endpackage

`default_nettype wire

// ----- hw/rtl/tfr_in_if.sv -----
// Source element channel: valid/ready handshake with one element per item.
`default_nettype none

interface tfr_in_if;
  import tfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] src_element;

  modport source (output valid, output src_element, input ready);
  modport sink   (input valid, input src_element, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tfr_out_if.sv -----
// Texel channel: valid/ready handshake with one packed texel per item.
`default_nettype none

interface tfr_out_if;
  import tfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] texel_rgba;
  logic               last_texel;

  modport source (output valid, output texel_rgba, output last_texel, input ready);
  modport sink   (input valid, input texel_rgba, input last_texel, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tfr_convert.sv -----
// Combinational expansion of one source element (or nibble) to RGBA8888.
`default_nettype none

module tfr_convert (
  input  wire logic [tfr_pkg::MODE_W-1:0]  mode,
  input  wire logic [tfr_pkg::ELEM_W-1:0]  element,
  input  wire logic                        sel_low,
  output logic      [tfr_pkg::TEXEL_W-1:0] texel
);
  import tfr_pkg::*;

  function automatic logic [7:0] widen5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [TEXEL_W-1:0] pack(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] a);
    return {a, b, g, r};
  endfunction

  logic [3:0] nib;
  logic [7:0] i3w;
  logic [7:0] n4w;
  logic [7:0] ia8_i;
  logic [7:0] ia8_a;

  // Pick high nibble first, then low nibble
  assign nib   = sel_low ? element[3:0] : element[7:4];
  assign i3w   = {nib[3:1], nib[3:1], nib[3:2]};
  assign n4w   = {nib, nib};
  assign ia8_i = {element[7:4], element[7:4]};
  assign ia8_a = {element[3:0], element[3:0]};

  // Expand per source format
  always_comb begin
    unique case (mode)
      MODE_RGBA16: texel = pack(widen5(element[15:11]), widen5(element[10:6]),
                                widen5(element[5:1]), {8{element[0]}});
      MODE_RGBA32: texel = element;
      MODE_IA16:   texel = pack(element[15:8], element[15:8], element[15:8], element[7:0]);
      MODE_IA8:    texel = pack(ia8_i, ia8_i, ia8_i, ia8_a);
      MODE_IA4:    texel = pack(i3w, i3w, i3w, {8{nib[0]}});
      MODE_I8:     texel = pack(element[7:0], element[7:0], element[7:0], 8'hFF);
      MODE_I4:     texel = pack(n4w, n4w, n4w, 8'hFF);
      default:     texel = MAGENTA_TEXEL;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/texel_format_to_rgba32.sv -----
// Texel expander: 1 element/cycle for one-texel formats unless the output stalls; the
// 4-bit formats (IA4, I4) hold each element until its nibbles have gone out, limited by
// the single texel output register. Elements pass the hold stage, then the output reg.
// The texel counter is advanced at element accept; formats that give nothing
// and elements past the texel total are accepted and dropped.
// Reset (synchronous, rst_n low) clears both registers, the counter and both stage valids.
`default_nettype none

module texel_format_to_rgba32 #(
  parameter int unsigned MAX_TEXELS = 1048576
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tfr_in_if.sink                              in_ch,
  tfr_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [tfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import tfr_pkg::*;

  // Configuration and counter
  logic [MODE_W-1:0]  mode_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] emitted_r;
  logic [TOTAL_W-1:0] emitted_nxt;

  // Hold stage
  logic              a_valid_r;
  logic [ELEM_W-1:0] a_elem_r;
  logic              a_two_r;
  logic              a_sel_r;
  logic              a_last0_r;
  logic              a_last1_r;

  // Output register
  logic               o_valid_r;
  logic [TEXEL_W-1:0] o_texel_r;
  logic               o_last_r;

  logic               cfg_wr;
  logic [TOTAL_W-1:0] total_eff;
  logic [TOTAL_W:0]   emit_p1;
  logic [TOTAL_W:0]   emit_p2;
  logic               full;
  logic               one_left;
  logic               dual;
  logic               single;
  logic [1:0]         n_texels;
  logic               in_acc;
  logic               a_adv;
  logic               a_final;
  logic [TEXEL_W-1:0] conv_texel;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_TEXEL_TOTAL) ? {{(CFG_DATA_W-TOTAL_W){1'b0}}, total_r}
                                                : {{(CFG_DATA_W-MODE_W){1'b0}}, mode_r};

  // Clamp total to capacity
  always_comb begin
    if ({{(32-TOTAL_W){1'b0}}, total_r} > 32'(MAX_TEXELS)) begin
      total_eff = TOTAL_W'(MAX_TEXELS);
    end else begin
      total_eff = total_r;
    end
  end

  // Count texels this element produces
  assign emit_p1  = {1'b0, emitted_r} + (TOTAL_W+1)'(1);
  assign emit_p2  = {1'b0, emitted_r} + (TOTAL_W+1)'(2);
  assign full     = (emitted_r >= total_eff);
  assign one_left = (emit_p1 == {1'b0, total_eff});
  assign dual     = (mode_r == MODE_IA4) || (mode_r == MODE_I4);
  assign single   = (mode_r <= MODE_I8) && !dual || (mode_r == MODE_MAGENTA);

  always_comb begin
    priority if (full) begin
      n_texels = 2'd0;
    end else if (dual) begin
      n_texels = one_left ? 2'd1 : 2'd2;
    end else if (single) begin
      n_texels = 2'd1;
    end else begin
      n_texels = 2'd0;
    end
  end

  assign emitted_nxt = emitted_r + TOTAL_W'(n_texels);

  // Handshake
  assign a_adv       = !o_valid_r || out_ch.ready;
  assign a_final     = !a_two_r || a_sel_r;
  assign in_ch.ready = !a_valid_r || (a_adv && a_final);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RGBA16;
      total_r   <= '0;
      emitted_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TEXEL_TOTAL) begin
        total_r <= pwdata[TOTAL_W-1:0];
      end else begin
        mode_r  <= pwdata[MODE_W-1:0];
      end
      emitted_r <= '0;
    end else if (in_acc) begin
      emitted_r <= emitted_nxt;
    end
  end

  // Hold stage: load on accept, step through nibbles, drop when done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_sel_r   <= 1'b0;
    end else if (in_acc && (n_texels != 2'd0)) begin
      a_valid_r <= 1'b1;
      a_sel_r   <= 1'b0;
    end else if (a_valid_r && a_adv && a_final) begin
      a_valid_r <= 1'b0;
    end else if (a_valid_r && a_adv) begin
      a_sel_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_elem_r  <= in_ch.src_element;
      a_two_r   <= (n_texels == 2'd2);
      a_last0_r <= one_left;
      a_last1_r <= (emit_p2 == {1'b0, total_eff});
    end
  end

  tfr_convert u_convert (
    .mode    (mode_r),
    .element (a_elem_r),
    .sel_low (a_sel_r),
    .texel   (conv_texel)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (a_valid_r && a_adv) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && a_adv) begin
      o_texel_r <= conv_texel;
      o_last_r  <= a_sel_r ? a_last1_r : a_last0_r;
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.texel_rgba = o_texel_r;
  assign out_ch.last_texel = o_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tfr_checker.sv -----
// Port-level checks for the texel expander, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tfr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [tfr_pkg::TEXEL_W-1:0]    out_texel,
  input wire logic                           out_last,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [tfr_pkg::CFG_ADDR_W-1:0] paddr,
  input wire logic [tfr_pkg::CFG_DATA_W-1:0] pwdata,
  input wire logic [tfr_pkg::CFG_DATA_W-1:0] prdata
);
  import tfr_pkg::*;

  logic wr_mode;
  logic in_acc;

  assign wr_mode = psel && penable && pwrite && (paddr[2] == REG_SOURCE_MODE);
  assign in_acc  = in_valid && in_ready;

  // Reset empties the output
  `TFR_ASSERT_NXT_ANY(a_reset_empty, !rst_n, !out_valid)

  // Stalled texel holds
  `TFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
                  out_valid && $stable(out_texel) && $stable(out_last))

  // A texel appears on an empty output only from an element accepted through the hold stage
  `TFR_ASSERT_IMP(a_rise_from_input, $rose(out_valid), $past(in_acc, 2))

  // Format register reads back what was written
  `TFR_ASSERT_IMP(a_mode_readback, wr_mode ##1 (paddr[2] == REG_SOURCE_MODE),
                  prdata == {{(CFG_DATA_W-MODE_W){1'b0}}, $past(pwdata[MODE_W-1:0])})

endmodule

bind texel_format_to_rgba32 tfr_checker u_tfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_texel (out_ch.texel_rgba),
  .out_last  (out_ch.last_texel),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for the texel expander: random traffic, stalls and a scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import tfr_pkg::*;

  localparam int unsigned MAX_TEXELS   = 1048576;
  localparam int unsigned DRAIN_CYCLES = 4;     // element accept to texel valid, plus margin
  localparam int unsigned STUCK_LIMIT  = 2000;  // cycles without any handshake
  localparam int unsigned ITEM_TARGET  = 1950;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel_rgba;
    logic               last_texel;
  } texel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic              elem_valid  = 1'b0;
  logic [ELEM_W-1:0] elem_data   = '0;
  logic              texel_ready = 1'b0;

  tfr_in_if  in_ch ();
  tfr_out_if out_ch ();

  assign in_ch.valid       = elem_valid;
  assign in_ch.src_element = elem_data;
  assign out_ch.ready      = texel_ready;

  texel_format_to_rgba32 #(
    .MAX_TEXELS(MAX_TEXELS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk = ~clk;

  // Shadow of the block's registers and texel counter
  logic [MODE_W-1:0]  cur_mode    = MODE_RGBA16;
  logic [TOTAL_W-1:0] cur_total   = '0;
  logic [TOTAL_W-1:0] texels_done = '0;

  logic [ELEM_W-1:0] elements_to_send[$];
  texel_t            texels_due[$];

  int unsigned error_count     = 0;
  int unsigned elems_accepted  = 0;
  int unsigned texels_checked  = 0;
  int unsigned last_flags_seen = 0;
  int unsigned textures_run    = 0;

  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  int unsigned quiet_left  = 0;
  bit          quiet_in    = 1'b0;
  bit          quiet_out   = 1'b0;
  int unsigned stuck_count = 0;

  // Widen a 5-bit channel by repeating its top bits
  function automatic logic [7:0] widen5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [TEXEL_W-1:0] ia4_texel(input logic [3:0] n);
    logic [7:0] i;
    i = {n[3:1], n[3:1], n[3:2]};
    return {(n[0] ? 8'hFF : 8'h00), i, i, i};
  endfunction

  function automatic logic [TEXEL_W-1:0] i4_texel(input logic [3:0] n);
    return {8'hFF, n, n, n, n, n, n};
  endfunction

  // Queue one texel unless the texture is already complete
  function automatic void emit_texel(input logic [TEXEL_W-1:0] texel);
    logic [TOTAL_W-1:0] limit;
    texel_t t;
    limit = (cur_total > MAX_TEXELS) ? TOTAL_W'(MAX_TEXELS) : cur_total;
    if (texels_done >= limit) return;
    texels_done = texels_done + 1'b1;
    t.texel_rgba = texel;
    t.last_texel = (texels_done == limit);
    texels_due.push_back(t);
  endfunction

  // Expand one source element into the texels it yields
  function automatic void expand_element(input logic [ELEM_W-1:0] e);
    logic [7:0] i;
    logic [7:0] a;
    case (cur_mode)
      MODE_RGBA16: begin
        a = e[0] ? 8'hFF : 8'h00;
        emit_texel({a, widen5(e[5:1]), widen5(e[10:6]), widen5(e[15:11])});
      end
      MODE_RGBA32: begin
        emit_texel(e);
      end
      MODE_IA16: begin
        emit_texel({e[7:0], e[15:8], e[15:8], e[15:8]});
      end
      MODE_IA8: begin
        i = {e[7:4], e[7:4]};
        a = {e[3:0], e[3:0]};
        emit_texel({a, i, i, i});
      end
      MODE_IA4: begin
        emit_texel(ia4_texel(e[7:4]));
        emit_texel(ia4_texel(e[3:0]));
      end
      MODE_I8: begin
        emit_texel({8'hFF, e[7:0], e[7:0], e[7:0]});
      end
      MODE_I4: begin
        emit_texel(i4_texel(e[7:4]));
        emit_texel(i4_texel(e[3:0]));
      end
      MODE_MAGENTA: begin
        emit_texel(MAGENTA_TEXEL);
      end
      default: begin
      end
    endcase
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Alternate stretches with and without idling on each side
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      quiet_in   <= ($urandom_range(0, 2) == 0);
      quiet_out  <= ($urandom_range(0, 2) == 0);
      quiet_left <= $urandom_range(40, 300);
    end else begin
      quiet_left <= quiet_left - 1;
    end
  end

  // Element driver: hold an item until taken, then idle or launch the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      elem_valid <= 1'b0;
      elem_data  <= '0;
      in_gap     <= 0;
    end else if (!elem_valid || in_ch.ready) begin
      if (in_gap != 0) begin
        elem_valid <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (elements_to_send.size() != 0) begin
        elem_valid <= 1'b1;
        elem_data  <= elements_to_send.pop_front();
        in_gap     <= pick_gap(quiet_in);
      end else begin
        elem_valid <= 1'b0;
      end
    end
  end

  // Texel receiver: drop ready for random stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      texel_ready <= 1'b0;
      out_stall   <= 0;
    end else if (out_stall != 0) begin
      texel_ready <= 1'b0;
      out_stall   <= out_stall - 1;
    end else begin
      texel_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_gap(quiet_out);
    end
  end

  // Monitor: predict on element accept, compare on texel accept
  always @(posedge clk) begin
    texel_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expand_element(in_ch.src_element);
        elems_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (texels_due.size() == 0) begin
          $error("unexpected texel: texel_rgba %h last_texel %b",
                 out_ch.texel_rgba, out_ch.last_texel);
          error_count++;
        end else begin
          want = texels_due.pop_front();
          texels_checked++;
          if (want.last_texel) last_flags_seen++;
          if (out_ch.texel_rgba !== want.texel_rgba) begin
            $error("texel_rgba mismatch: expected %h, actual %h",
                   want.texel_rgba, out_ch.texel_rgba);
            error_count++;
          end
          if (out_ch.last_texel !== want.last_texel) begin
            $error("last_texel mismatch: expected %b, actual %b",
                   want.last_texel, out_ch.last_texel);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_count <= 0;
    end else if (stuck_count >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_count <= stuck_count + 1;
    end
  end

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SOURCE_MODE) cur_mode = value[MODE_W-1:0];
    else cur_total = value[TOTAL_W-1:0];
    texels_done = '0;
  endtask

  // Wait until nothing is queued, in flight or expected, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (elements_to_send.size() != 0 || elem_valid || texels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Begin a new texture; either register write restarts the counter
  task automatic start_texture(input logic [MODE_W-1:0] mode, input logic [31:0] total,
                               input bit set_mode, input bit set_total);
    wait_idle();
    if (set_mode) write_register(REG_SOURCE_MODE, 32'(mode));
    if (set_total) write_register(REG_TEXEL_TOTAL, total);
    textures_run++;
    @(negedge clk);
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    logic [31:0]       total;
    int unsigned       n;
    int unsigned       r;
    int unsigned       planned;
    bit                split;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: channel extremes, high bits ignored, exact maximum total
    start_texture(MODE_RGBA16, MAX_TEXELS, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_0000);
    elements_to_send.push_back(32'h0000_FFFF);
    elements_to_send.push_back(32'hFFFF_0000);
    elements_to_send.push_back(32'h0000_8421);
    // Pass-through with an oversized total, upper write bits set
    start_texture(MODE_RGBA32, 32'hFFFF_FFFF, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_0000);
    elements_to_send.push_back(32'hFFFF_FFFF);
    elements_to_send.push_back(32'h1234_5678);
    start_texture(MODE_IA16, 100, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_FF00);
    elements_to_send.push_back(32'hFFFF_00FF);
    start_texture(MODE_IA8, 100, 1'b1, 1'b0);
    elements_to_send.push_back(32'hFFFF_FF5A);
    elements_to_send.push_back(32'h0000_000F);
    // Odd total ends after a high nibble, then the texture is complete
    start_texture(MODE_IA4, 3, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_00F0);
    elements_to_send.push_back(32'hFFFF_FF1E);
    elements_to_send.push_back(32'h0000_00FF);
    // Zero total yields nothing
    start_texture(MODE_I8, 0, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_00AB);
    elements_to_send.push_back(32'hFFFF_FFFF);
    start_texture(MODE_I4, 1, 1'b1, 1'b1);
    elements_to_send.push_back(32'hFFFF_FFC3);
    start_texture(MODE_MAGENTA, 2, 1'b1, 1'b1);
    elements_to_send.push_back(32'h0000_0000);
    elements_to_send.push_back(32'hFFFF_FFFF);
    elements_to_send.push_back(32'h5555_AAAA);
    // Unimplemented and meaningless selectors yield nothing
    start_texture(MODE_UNIMPL, 50, 1'b1, 1'b1);
    elements_to_send.push_back(32'hDEAD_BEEF);
    start_texture('1, 50, 1'b1, 1'b0);
    elements_to_send.push_back(32'h0123_4567);

    // Random textures: mostly real formats and totals small enough to finish
    planned = 0;
    while (planned < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      mode = (r < 88) ? MODE_W'($urandom_range(0, 7))
                      : MODE_W'($urandom_range(int'(MODE_UNIMPL), 15));
      r = $urandom_range(0, 99);
      if (r < 60)      total = $urandom_range(1, 64);
      else if (r < 75) total = $urandom_range(65, 2000);
      else if (r < 83) total = MAX_TEXELS;
      else if (r < 91) total = $urandom_range(MAX_TEXELS + 1, (1 << TOTAL_W) - 1);
      else if (r < 96) total = 1;
      else             total = 0;
      r = $urandom_range(0, 99);
      if (r < 70)      start_texture(mode, total, 1'b1, 1'b1);
      else if (r < 85) start_texture(mode, total, 1'b1, 1'b0);
      else             start_texture(mode, total, 1'b0, 1'b1);
      n     = $urandom_range(8, 80);
      split = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n; k++) begin
        // Pause mid-texture until every queued texel has come back
        if (split && k == n / 2) wait_idle();
        elements_to_send.push_back($urandom);
      end
      planned += n;
    end

    wait_idle();
    $display("Ran %0d textures: %0d elements accepted, %0d texels checked,",
             textures_run, elems_accepted, texels_checked);
    $display("%0d end-of-texture flags; all source formats, zero/odd/oversized totals, stalls.",
             last_flags_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
